// ===== sv/kmsa_pkg.sv =====
`default_nettype none
package kmsa_pkg;

   localparam int KEY_W    = 7;
   localparam int KIND_W   = 2;
   localparam int MAP_BITS = 15;

   localparam logic [KIND_W-1:0] KIND_KEY_DOWN = 2'd0;
   localparam logic [KIND_W-1:0] KIND_KEY_UP   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MOD_DOWN = 2'd2;
   localparam logic [KIND_W-1:0] KIND_MOD_UP   = 2'd3;

   // fixed modifier keys; the programmable altgr index is a modifier as well
   localparam int MOD_COUNT = 6;
   localparam logic [KEY_W-1:0] MOD_KEYS [MOD_COUNT] = '{
      7'd45, 7'd57, 7'd60, 7'd61, 7'd62, 7'd69
   };

   localparam logic [KEY_W-1:0] ALTGR_RESET     = 7'd69;
   localparam logic [KEY_W-1:0] LAYER_TWO_RESET = 7'd11;

   localparam logic CSR_ALTGR     = 1'b0;
   localparam logic CSR_LAYER_TWO = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [KIND_W-1:0] kind;
      logic              layer_two;
      logic              indicator;
   } event_type;

   typedef struct packed {
      logic load;
      logic step;
      logic inject;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic last_col;
      logic two_events;
      logic hold_valid;
      logic can_push;
   } status_type;

endpackage
`default_nettype wire

// ===== sv/kmsa_ctrl.sv =====
`default_nettype none
module kmsa_ctrl
   import kmsa_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_INJECT,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = ST_WALK;
         end
         ST_WALK: begin
            cmd.step = status.can_push;
            if (status.can_push) begin
               if (status.two_events) state_in = ST_INJECT;
               else if (status.last_col) state_in = ST_FINISH;
            end
         end
         ST_INJECT: begin
            cmd.inject = status.can_push;
            if (status.can_push) state_in = status.last_col ? ST_FINISH : ST_WALK;
         end
         ST_FINISH: begin
            // the pending event goes out tagged as the last one of the item
            cmd.flush = status.hold_valid && status.can_push;
            if (!status.hold_valid || status.can_push) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != ST_IDLE);
      end
   end

   assign req_stall = req_stall_ff;

`ifndef SYNTHESIS
   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == ST_IDLE && !req_stall_ff)
      else $error("item loaded outside idle");
   a_stall_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> req_stall)
      else $error("input not stalled during walk");
   a_inject_follows_split: assert property (@(posedge clock) disable iff (reset)
      cmd.inject |-> $past(cmd.step && status.two_events) || state_ff == ST_INJECT)
      else $error("inject without split event");
`endif

endmodule
`default_nettype wire

// ===== sv/kmsa_dp.sv =====
`default_nettype none
module kmsa_dp
   import kmsa_pkg::*;
#(
   parameter int ROW_COUNT    = 5,
   parameter int COLUMN_COUNT = 15
)(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire logic [MAP_BITS-1:0] req_column_closed,
   input  wire logic                csr_valid,
   input  wire logic                csr_index,
   input  wire logic [KEY_W-1:0]    csr_wdata,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [KEY_W-1:0]         rsp_key_index,
   output logic [KIND_W-1:0]        rsp_event_kind,
   output logic                     rsp_use_layer_two,
   output logic                     rsp_layer_indicator,
   output logic                     rsp_last_event
);

   localparam int NCOL     = (COLUMN_COUNT < MAP_BITS) ? COLUMN_COUNT : MAP_BITS;
   localparam int COL_W    = (NCOL > 1) ? $clog2(NCOL) : 1;
   localparam int ROW_W    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam int IDX_SPAN = ROW_COUNT * COLUMN_COUNT;
   localparam int IDX_W    = (IDX_SPAN > 1) ? $clog2(IDX_SPAN) : 1;
   localparam int CMP_W    = (IDX_W > KEY_W) ? IDX_W : KEY_W;

   // configuration
   logic [KEY_W-1:0] altgr_ff, layer_two_ff;

   // scan state
   logic [NCOL-1:0]  map_ff [ROW_COUNT];
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CMP_W-1:0] base_ff, base_in;
   logic             active_ff, active_in;
   logic             swallow_ff, swallow_in;

   // walk state
   logic [NCOL-1:0]  now_ff, changed_ff, now_row;
   logic [COL_W-1:0] col_ff, col_in;
   logic [CMP_W-1:0] col_idx_ff, col_idx_in;

   // pending event and output register
   event_type hold_ff, hold_in, rsp_ff, rsp_in, ev, inj_ev, push_ev;
   logic      hold_valid_ff, hold_valid_in;
   logic      rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;

   logic is_altgr, is_layer_two, is_mod, chg, down, ev_valid, two_events;
   logic push_valid, taken, advance;

   assign now_row = req_column_closed[NCOL-1:0];

   // event decision for the current column
   always_comb begin
      is_altgr     = (col_idx_ff == CMP_W'(altgr_ff));
      is_layer_two = (col_idx_ff == CMP_W'(layer_two_ff));
      is_mod       = is_altgr;
      for (int i = 0; i < MOD_COUNT; i++) begin
         if (col_idx_ff == CMP_W'(MOD_KEYS[i])) is_mod = 1'b1;
      end
      chg        = changed_ff[col_ff];
      down       = now_ff[col_ff];
      ev_valid   = 1'b0;
      two_events = 1'b0;
      active_in  = active_ff;
      swallow_in = swallow_ff;
      ev         = '{key: col_idx_ff[KEY_W-1:0], kind: KIND_KEY_DOWN,
                     layer_two: 1'b0, indicator: active_ff};
      if (chg) begin
         ev_valid = 1'b1;
         if (down) begin
            if (is_mod) begin
               ev.kind = KIND_MOD_DOWN;
               if (is_altgr) begin
                  active_in    = 1'b1;
                  ev.indicator = 1'b1;
               end
            end else if (active_ff && is_layer_two) begin
               // altgr up first, the layer key follows from the inject state
               two_events = 1'b1;
               ev.key     = altgr_ff;
               ev.kind    = KIND_MOD_UP;
            end
         end else begin
            if (active_ff && is_layer_two) begin
               swallow_in   = 1'b1;
               ev.kind      = KIND_KEY_UP;
               ev.layer_two = 1'b1;
            end else if (is_mod) begin
               if (is_altgr && swallow_ff) begin
                  active_in  = 1'b0;
                  swallow_in = 1'b0;
                  ev_valid   = 1'b0;
               end else begin
                  ev.kind = KIND_MOD_UP;
                  if (is_altgr) begin
                     active_in    = 1'b0;
                     ev.indicator = 1'b0;
                  end
               end
            end else begin
               ev.kind = KIND_KEY_UP;
            end
         end
      end
      inj_ev = '{key: col_idx_ff[KEY_W-1:0], kind: KIND_KEY_DOWN,
                 layer_two: 1'b1, indicator: active_ff};
   end

   assign taken      = rsp_valid_ff && !rsp_stall;
   assign push_valid = (cmd.step && ev_valid) || cmd.inject;
   assign push_ev    = cmd.inject ? inj_ev : ev;
   assign advance    = cmd.inject || (cmd.step && !two_events);

   always_comb begin
      col_in     = col_ff;
      col_idx_in = col_idx_ff;
      row_in     = row_ff;
      base_in    = base_ff;
      if (cmd.load) begin
         col_in     = '0;
         col_idx_in = base_ff;
         if (row_ff == ROW_W'(ROW_COUNT - 1)) begin
            row_in  = '0;
            base_in = '0;
         end else begin
            row_in  = row_ff + ROW_W'(1);
            base_in = base_ff + CMP_W'(COLUMN_COUNT);
         end
      end else if (advance) begin
         col_in     = col_ff + COL_W'(1);
         col_idx_in = col_idx_ff + CMP_W'(1);
      end
   end

   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !taken;
      if (push_valid) begin
         // an event is only sent once the next one shows it is not the last
         if (hold_valid_ff) begin
            rsp_in       = hold_ff;
            rsp_last_in  = 1'b0;
            rsp_valid_in = 1'b1;
         end
         hold_in       = push_ev;
         hold_valid_in = 1'b1;
      end else if (cmd.flush) begin
         rsp_in        = hold_ff;
         rsp_last_in   = 1'b1;
         rsp_valid_in  = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         altgr_ff      <= ALTGR_RESET;
         layer_two_ff  <= LAYER_TWO_RESET;
         row_ff        <= '0;
         base_ff       <= '0;
         active_ff     <= 1'b0;
         swallow_ff    <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int r = 0; r < ROW_COUNT; r++) begin
            map_ff[r] <= '0;
         end
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_ALTGR:     altgr_ff     <= csr_wdata;
               CSR_LAYER_TWO: layer_two_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load) map_ff[row_ff] <= now_row;
         if (cmd.step) begin
            active_ff  <= active_in;
            swallow_ff <= swallow_in;
         end
         row_ff        <= row_in;
         base_ff       <= base_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff     <= now_row;
         changed_ff <= now_row ^ map_ff[row_ff];
      end
      col_ff      <= col_in;
      col_idx_ff  <= col_idx_in;
      hold_ff     <= hold_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.last_col   = (col_ff == COL_W'(NCOL - 1));
   assign status.two_events = two_events;
   assign status.hold_valid = hold_valid_ff;
   assign status.can_push   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_key_index       = rsp_ff.key;
   assign rsp_event_kind      = rsp_ff.kind;
   assign rsp_use_layer_two   = rsp_ff.layer_two;
   assign rsp_layer_indicator = rsp_ff.indicator;
   assign rsp_last_event      = rsp_last_ff;

`ifndef SYNTHESIS
   a_swallow_needs_layer: assert property (@(posedge clock) disable iff (reset)
      swallow_ff |-> active_ff)
      else $error("swallow flag set without altgr layer");
   a_push_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.step || cmd.inject || cmd.flush) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("event pushed into a busy output register");
   a_split_leaves_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.step && two_events |=> hold_valid_ff && hold_ff.kind == KIND_MOD_UP)
      else $error("altgr release not pending before layer key");
   a_flush_has_event: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> rsp_valid_ff && rsp_last_ff && !hold_valid_ff)
      else $error("flush without a pending event");
`endif

endmodule
`default_nettype wire

// ===== sv/key_matrix_scan_with_altgr_layer.sv =====
// Keyboard matrix scanner with an AltGr layer. Each input item is the closed-column
// bits of the row now driven; the block walks the columns of that row in ascending
// order and sends one result item per key event (key or modifier down/up, with the
// layer-two remap under AltGr), the final one of the item flagged by rsp_last_event.
// An item with no changed column gives no result and still advances the row. Each
// item is loaded, then its columns pass through the single event decision unit and a
// final step sends the last event; a layer-two key press under AltGr adds an inject
// step, and rsp_stall holding the output register stalls the walk. The next item is
// taken while the last result still waits in that register. csr_ready is always high;
// the user writes registers only while idle; the block itself does not enforce it.
`default_nettype none
module key_matrix_scan_with_altgr_layer
   import kmsa_pkg::*;
#(
   parameter int ROW_COUNT    = 5,
   parameter int COLUMN_COUNT = 15
)(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [MAP_BITS-1:0] req_column_closed,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [KEY_W-1:0]         rsp_key_index,
   output logic [KIND_W-1:0]        rsp_event_kind,
   output logic                     rsp_use_layer_two,
   output logic                     rsp_layer_indicator,
   output logic                     rsp_last_event,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic                csr_index,
   input  wire logic [KEY_W-1:0]    csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   kmsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   kmsa_dp #(
      .ROW_COUNT    (ROW_COUNT),
      .COLUMN_COUNT (COLUMN_COUNT)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_column_closed   (req_column_closed),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_key_index       (rsp_key_index),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_use_layer_two   (rsp_use_layer_two),
      .rsp_layer_indicator (rsp_layer_indicator),
      .rsp_last_event      (rsp_last_event)
   );

endmodule
`default_nettype wire

// ===== tb/key_event_checker.sv =====
module key_event_checker
   import kmsa_pkg::*;
#(
   parameter int ROWS = 5,
   parameter int COLS = 15
)(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_stall,
   input  wire logic [MAP_BITS-1:0] req_column_closed,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_stall,
   input  wire logic [KEY_W-1:0]    rsp_key_index,
   input  wire logic [KIND_W-1:0]   rsp_event_kind,
   input  wire logic                rsp_use_layer_two,
   input  wire logic                rsp_layer_indicator,
   input  wire logic                rsp_last_event,
   input  wire logic                csr_valid,
   input  wire logic                csr_ready,
   input  wire logic                csr_index,
   input  wire logic [KEY_W-1:0]    csr_wdata,
   output int                       fail_count,
   output int                       events_waiting,
   output int                       events_seen
);

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [KIND_W-1:0] kind;
      logic              layer_two;
      logic              indicator;
      logic              last;
   } key_event_type;

   key_event_type       pending_events[$];
   key_event_type       held_back;
   key_event_type       wanted;
   logic                held_back_valid;
   logic [MAP_BITS-1:0] row_keys [ROWS];
   int                  scan_row;
   logic                layer_on;
   logic                swallow_release;
   logic [KEY_W-1:0]    altgr_key;
   logic [KEY_W-1:0]    layer_key;
   int                  errors = 0;
   int                  seen = 0;

   assign fail_count  = errors;
   assign events_seen = seen;

   function automatic logic is_modifier(input logic [KEY_W-1:0] idx);
      logic hit;
      int   i;
      hit = (idx == altgr_key);
      for (i = 0; i < MOD_COUNT; i++) begin
         if (idx == MOD_KEYS[i]) hit = 1'b1;
      end
      return hit;
   endfunction

   // the newest event is held back so the final one of a scan can get its last flag
   task automatic queue_event(input logic [KEY_W-1:0] key, input logic [KIND_W-1:0] kind,
                              input logic layer_two);
      if (held_back_valid) pending_events.push_back(held_back);
      held_back.key       = key;
      held_back.kind      = kind;
      held_back.layer_two = layer_two;
      held_back.indicator = layer_on;
      held_back.last      = 1'b0;
      held_back_valid     = 1'b1;
   endtask

   task automatic decode_row_scan(input logic [MAP_BITS-1:0] cols);
      logic [MAP_BITS-1:0] changed;
      logic [KEY_W-1:0]    idx;
      int                  c;
      held_back_valid = 1'b0;
      changed = cols ^ row_keys[scan_row];
      for (c = 0; c < COLS && c < MAP_BITS; c++) begin
         if (changed[c]) begin
            idx = KEY_W'(scan_row * COLS + c);
            if (cols[c]) begin
               // modifier check wins over the layer remap on a press
               if (is_modifier(idx)) begin
                  if (idx == altgr_key) layer_on = 1'b1;
                  queue_event(idx, KIND_MOD_DOWN, 1'b0);
               end else if (layer_on && idx == layer_key) begin
                  queue_event(altgr_key, KIND_MOD_UP, 1'b0);
                  queue_event(idx, KIND_KEY_DOWN, 1'b1);
               end else begin
                  queue_event(idx, KIND_KEY_DOWN, 1'b0);
               end
            end else if (layer_on && idx == layer_key) begin
               swallow_release = 1'b1;
               queue_event(idx, KIND_KEY_UP, 1'b1);
            end else if (is_modifier(idx)) begin
               if (idx == altgr_key && swallow_release) begin
                  layer_on        = 1'b0;
                  swallow_release = 1'b0;
               end else begin
                  if (idx == altgr_key) layer_on = 1'b0;
                  queue_event(idx, KIND_MOD_UP, 1'b0);
               end
            end else begin
               queue_event(idx, KIND_KEY_UP, 1'b0);
            end
         end
      end
      if (held_back_valid) begin
         held_back.last = 1'b1;
         pending_events.push_back(held_back);
      end
      row_keys[scan_row] = cols;
      scan_row = (scan_row + 1) % ROWS;
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pending_events.delete();
         foreach (row_keys[r]) row_keys[r] = '0;
         scan_row        = 0;
         layer_on        = 1'b0;
         swallow_release = 1'b0;
         altgr_key       = ALTGR_RESET;
         layer_key       = LAYER_TWO_RESET;
         events_waiting <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ALTGR) altgr_key = csr_wdata;
            else layer_key = csr_wdata;
         end
         if (req_valid && !req_stall) decode_row_scan(req_column_closed);
         if (rsp_valid && !rsp_stall) begin
            seen++;
            if (pending_events.size() == 0) begin
               errors++;
               $display("%0t: key event expected none, got index %0d kind %0d", $time,
                        rsp_key_index, rsp_event_kind);
            end else begin
               wanted = pending_events.pop_front();
               check_field("key_index", wanted.key, rsp_key_index);
               check_field("event_kind", wanted.kind, rsp_event_kind);
               check_field("use_layer_two", wanted.layer_two, rsp_use_layer_two);
               check_field("layer_indicator", wanted.indicator, rsp_layer_indicator);
               check_field("last_event", wanted.last, rsp_last_event);
            end
         end
         events_waiting <= pending_events.size();
      end
   end

endmodule

// ===== tb/key_matrix_scan_with_altgr_layer_test.sv =====
module key_matrix_scan_with_altgr_layer_test;
   import kmsa_pkg::*;

   localparam int ROWS          = 5;
   localparam int COLS          = 15;
   localparam int PHASES        = 6;
   localparam int RANDOM_ITEMS  = 23;  // per register setting
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int PRESSURE_AT   = 130;
   localparam int CYCLE_LIMIT   = 400000;

   // rows come in order 0..4; see the phase comments below
   localparam logic [MAP_BITS-1:0] DIRECTED_SCANS [25] = '{
      15'h7FFF, 15'h0000, 15'h0000, 15'h1001, 15'h7FFF,  // rows 0 and 4 and every modifier down
      15'h7FFF, 15'h0000, 15'h0000, 15'h0000, 15'h0000,  // row 0 unchanged, rows 3 and 4 up
      15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0200,  // row 0 up, altgr down
      15'h0800, 15'h0000, 15'h0000, 15'h0000, 15'h0200,  // layer key under altgr
      15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000   // layer key up, altgr up swallowed
   };
   localparam logic [KEY_W-1:0] PHASE_ALTGR [PHASES] = '{
      7'd0, 7'd74, 7'd33, 7'd12, 7'd61, ALTGR_RESET
   };
   localparam logic [KEY_W-1:0] PHASE_LAYER [PHASES] = '{
      7'd74, 7'd0, 7'd33, 7'd45, 7'd57, LAYER_TWO_RESET
   };

   typedef enum {
      PRESS_ALTGR, PRESS_LAYER, RELEASE_FIRST, RELEASE_SECOND, NO_CHORD
   } chord_step_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [MAP_BITS-1:0] req_column_closed = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [KEY_W-1:0]    rsp_key_index;
   logic [KIND_W-1:0]   rsp_event_kind;
   logic                rsp_use_layer_two;
   logic                rsp_layer_indicator;
   logic                rsp_last_event;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = CSR_ALTGR;
   logic [KEY_W-1:0]    csr_wdata = '0;

   int                  fail_count;
   int                  events_waiting;
   int                  events_seen;

   int                  idle_pct = 13;
   int                  stall_pct = 76;
   int                  items_sent = 0;
   int                  cycle_count = 0;
   int                  hold_left = 0;
   logic                pressure_done = 1'b0;

   logic [MAP_BITS-1:0] held [ROWS];
   int                  row_now = 0;
   chord_step_type      chord = NO_CHORD;
   logic                release_altgr_first = 1'b0;
   logic [KEY_W-1:0]    cur_altgr = ALTGR_RESET;
   logic [KEY_W-1:0]    cur_layer = LAYER_TWO_RESET;
   int                  phase;
   int                  i;

   key_matrix_scan_with_altgr_layer i_dut (.*);

   key_event_checker #(.ROWS(ROWS), .COLS(COLS)) i_checker (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("key_matrix_scan_with_altgr_layer verification failed");
         $finish;
      end
   end

   // receiver: random stalls plus one long hold-off that backs the block up
   always @(posedge clock) begin
      if (reset) begin
         hold_left     <= 0;
         pressure_done <= 1'b0;
      end else if (!pressure_done && items_sent == PRESSURE_AT) begin
         hold_left     <= HOLD_CYCLES;
         pressure_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
      rsp_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
   end

   task automatic send_scan(input logic [MAP_BITS-1:0] cols);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_column_closed <= cols;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent <= items_sent + 1;
      row_now = (row_now + 1) % ROWS;
   endtask

   // mostly altgr / layer key chords in either release order, with random key noise
   task automatic random_scan();
      logic [KEY_W-1:0] target;
      logic             press;
      int               pick;
      int               col;
      if (chord == NO_CHORD && $urandom_range(99) < 40) begin
         chord = PRESS_ALTGR;
         release_altgr_first = 1'($urandom_range(1));
      end
      if (chord != NO_CHORD) begin
         case (chord)
            PRESS_ALTGR: begin
               target = cur_altgr;
               press  = 1'b1;
            end
            PRESS_LAYER: begin
               target = cur_layer;
               press  = 1'b1;
            end
            RELEASE_FIRST: begin
               target = release_altgr_first ? cur_altgr : cur_layer;
               press  = 1'b0;
            end
            default: begin
               target = release_altgr_first ? cur_layer : cur_altgr;
               press  = 1'b0;
            end
         endcase
         // a chord step only lands on a scan of the row holding its key
         if (int'(target) / COLS == row_now && $urandom_range(3) != 0) begin
            held[row_now][int'(target) % COLS] = press;
            chord = (chord == RELEASE_SECOND) ? NO_CHORD : chord_step_type'(chord + 1);
         end
      end
      pick = $urandom_range(99);
      col  = $urandom_range(COLS - 1);
      if (pick < 25) held[row_now][col] = ~held[row_now][col];
      else if (pick < 33) held[row_now] = MAP_BITS'($urandom_range(32767));
      send_scan(held[row_now]);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (events_waiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_layer_keys(input logic [KEY_W-1:0] altgr, input logic [KEY_W-1:0] layer);
      csr_valid <= 1'b1;
      csr_index <= CSR_ALTGR;
      csr_wdata <= altgr;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_LAYER_TWO;
      csr_wdata <= layer;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_altgr = altgr;
      cur_layer = layer;
   endtask

   initial begin
      foreach (held[r]) held[r] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < 25; i++) begin
         held[row_now] = DIRECTED_SCANS[i];
         send_scan(held[row_now]);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 2) begin
            idle_pct  <= 76;
            stall_pct <= 13;
         end else if (phase == 4) begin
            idle_pct  <= 0;
            stall_pct <= 0;
         end
         settle();
         set_layer_keys(PHASE_ALTGR[phase], PHASE_LAYER[phase]);
         for (i = 0; i < RANDOM_ITEMS; i++) random_scan();
      end
      settle();

      $display("%0d row scans under %0d altgr/layer key settings", items_sent, PHASES + 1);
      $display("%0d key events compared, one long output hold-off", events_seen);
      if (fail_count == 0) begin
         $display("key_matrix_scan_with_altgr_layer verification clean");
      end else begin
         $display("key_matrix_scan_with_altgr_layer verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/kmsa_pkg.sv
sv/kmsa_ctrl.sv
sv/kmsa_dp.sv
sv/key_matrix_scan_with_altgr_layer.sv
tb/key_event_checker.sv
tb/key_matrix_scan_with_altgr_layer_test.sv
